// ===== src/cpdb_pkg.sv =====
// Package for the complementary PWM generator with dead band.
// Holds field widths, reset values, register indexes and the item structs.
// No dependencies.
package cpdb_pkg;

  localparam int COUNT_W = 16;
  localparam int DELAY_W = 14;
  localparam int CFG_INDEX_W = 1;

  localparam logic [COUNT_W-1:0] RESET_PERIOD  = COUNT_W'(999);
  localparam logic [COUNT_W-1:0] RESET_COMPARE = COUNT_W'(500);
  localparam logic [DELAY_W-1:0] RESET_DELAY   = DELAY_W'(4);

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_RISE_DELAY = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_FALL_DELAY = 1'b1;

  typedef struct packed {
    logic [COUNT_W-1:0] next_period;
    logic [COUNT_W-1:0] next_compare;
    logic               output_enable;
  } cpdb_in_t;

  typedef struct packed {
    logic               pwm_high_side;
    logic               pwm_low_side;
    logic               zero_event;
    logic [COUNT_W-1:0] count_value;
  } cpdb_out_t;

  // Levels produced by the dead-band unit for the current tick.
  typedef struct packed {
    logic rise_level;
    logic fall_level;
  } cpdb_db_levels_t;

endpackage

// ===== src/cpdb_dead_band.sv =====
// Dead-band unit: rising-edge delay for output A, falling-edge delay for B.
// Holds its own timers and delayed levels. Depends on cpdb_pkg.
module cpdb_dead_band (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            advance,
  input  logic                            raw_level,
  input  logic [cpdb_pkg::DELAY_W-1:0]    rise_delay,
  input  logic [cpdb_pkg::DELAY_W-1:0]    fall_delay,
  output cpdb_pkg::cpdb_db_levels_t       levels
);
  import cpdb_pkg::*;

  logic [DELAY_W-1:0] rise_timer;
  logic [DELAY_W-1:0] rise_timer_next;
  logic [DELAY_W-1:0] fall_timer;
  logic [DELAY_W-1:0] fall_timer_next;
  logic               delayed_rise_level;
  logic               delayed_rise_level_next;
  logic               delayed_fall_level;
  logic               delayed_fall_level_next;

  always_comb begin
    rise_timer_next         = rise_timer;
    delayed_rise_level_next = delayed_rise_level;
    if (raw_level) begin
      if (rise_timer < rise_delay) begin
        rise_timer_next         = rise_timer + DELAY_W'(1);
        delayed_rise_level_next = 1'b0;
      end else begin
        delayed_rise_level_next = 1'b1;
      end
    end else begin
      rise_timer_next         = '0;
      delayed_rise_level_next = 1'b0;
    end
  end

  // The falling level holds high for fall_delay ticks after the raw level drops.
  always_comb begin
    fall_timer_next         = fall_timer;
    delayed_fall_level_next = delayed_fall_level;
    if (raw_level) begin
      fall_timer_next         = '0;
      delayed_fall_level_next = 1'b1;
    end else if (delayed_fall_level && (fall_timer < fall_delay)) begin
      fall_timer_next = fall_timer + DELAY_W'(1);
    end else begin
      delayed_fall_level_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rise_timer         <= '0;
      fall_timer         <= '0;
      delayed_rise_level <= 1'b0;
      delayed_fall_level <= 1'b0;
    end else if (advance) begin
      rise_timer         <= rise_timer_next;
      fall_timer         <= fall_timer_next;
      delayed_rise_level <= delayed_rise_level_next;
      delayed_fall_level <= delayed_fall_level_next;
    end
  end

  assign levels.rise_level = delayed_rise_level_next;
  assign levels.fall_level = delayed_fall_level_next;

endmodule

// ===== src/complementary_pwm_dead_band.sv =====
// Top level of the complementary PWM generator with dead band.
// Timebase counter, shadow loads, raw level and result register.
// Depends on cpdb_pkg and cpdb_dead_band.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid / in_ready        in_data  (cpdb_in_t)
//   out      output     out_valid / out_ready      out_data (cpdb_out_t)
//   cfg      input      cfg_write_en               cfg_index, cfg_data
//
// One item is one timebase tick; a new item is accepted
// every cycle while the result register is empty or being drained.
// The result appears on out_data in the cycle after the item is accepted.
// Reset (rst, synchronous) loads period 999, compare 500 and delays of 4.
// A stall on out holds the result and stops in_ready until it is taken.
module complementary_pwm_dead_band (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  cpdb_pkg::cpdb_in_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output cpdb_pkg::cpdb_out_t                out_data,
  input  logic                               cfg_write_en,
  input  logic [cpdb_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [cpdb_pkg::DELAY_W-1:0]       cfg_data
);
  import cpdb_pkg::*;

  logic [DELAY_W-1:0] rise_delay;
  logic [DELAY_W-1:0] fall_delay;

  logic [COUNT_W-1:0] time_count;
  logic [COUNT_W-1:0] time_count_next;
  logic [COUNT_W-1:0] active_period;
  logic [COUNT_W-1:0] active_period_next;
  logic [COUNT_W-1:0] active_compare;
  logic [COUNT_W-1:0] active_compare_next;
  logic               raw_level;
  logic               raw_level_next;

  logic               accept;
  logic               at_zero;
  cpdb_db_levels_t    db_levels;
  cpdb_out_t          result_next;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign at_zero  = (time_count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      rise_delay <= RESET_DELAY;
      fall_delay <= RESET_DELAY;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_RISE_DELAY: rise_delay <= cfg_data;
        REG_FALL_DELAY: fall_delay <= cfg_data;
        default: ;
      endcase
    end
  end

  // Shadow values take effect on the zero tick itself; a compare match
  // clears the raw level even on the tick that sets it.
  always_comb begin
    active_period_next  = at_zero ? in_data.next_period  : active_period;
    active_compare_next = at_zero ? in_data.next_compare : active_compare;
    raw_level_next      = at_zero ? 1'b1 : raw_level;
    if (time_count == active_compare_next) begin
      raw_level_next = 1'b0;
    end
    if (time_count >= active_period_next) begin
      time_count_next = '0;
    end else begin
      time_count_next = time_count + COUNT_W'(1);
    end
  end

  cpdb_dead_band u_dead_band (
    .clk        (clk),
    .rst        (rst),
    .advance    (accept),
    .raw_level  (raw_level_next),
    .rise_delay (rise_delay),
    .fall_delay (fall_delay),
    .levels     (db_levels)
  );

  always_comb begin
    result_next.pwm_high_side = in_data.output_enable && db_levels.rise_level;
    result_next.pwm_low_side  = in_data.output_enable && !db_levels.fall_level;
    result_next.zero_event    = at_zero;
    result_next.count_value   = time_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_count     <= '0;
      active_period  <= RESET_PERIOD;
      active_compare <= RESET_COMPARE;
      raw_level      <= 1'b0;
    end else if (accept) begin
      time_count     <= time_count_next;
      active_period  <= active_period_next;
      active_compare <= active_compare_next;
      raw_level      <= raw_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result_next;
    end
  end

endmodule
